/* design/assert_macros.svh */
// assertion helpers used by the rtl controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// condition must never be seen at a clock edge
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed: forbidden condition");
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication violated");
`else
`define ASSERT_NEVER(lbl, clk, rst, expr)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

/* design/bdp_pkg.sv */
`timescale 1ns / 1ps

package bdp_pkg;

  // octet limit per string and counter width
  localparam int MAX_OCTETS = 32;
  localparam int SENT_W     = $clog2(MAX_OCTETS + 1);
  localparam int LEN_W      = 6;

  // character and fill constants
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [3:0] FILL_NIBBLE = 4'hF;
  localparam logic [7:0] PAD_OCTET   = 8'hFF;

  // register indexes on the config port
  typedef enum logic [1:0] {
    REG_SKIP_FIRST     = 2'd0,
    REG_LEADING_NIBBLE = 2'd1,
    REG_PAD_ENABLE     = 2'd2,
    REG_OCTET_LENGTH   = 2'd3
  } reg_index_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_TAIL,
    S_PAD
  } state_t;

  // which result the datapath builds
  typedef enum logic [2:0] {
    EK_BAD_CHAR,
    EK_TOO_LONG,
    EK_PAIR,
    EK_TAIL,
    EK_PAD
  } emit_kind_t;

  typedef struct packed {
    logic             skip_first;
    logic [3:0]       leading_nibble;
    logic             pad_enable;
    logic [LEN_W-1:0] octet_length;
  } cfg_t;

  typedef struct packed {
    logic       accept;
    logic       settle;
    logic       hold_digit;
    logic       clear_held;
    logic       count;
    logic       drop;
    logic       new_string;
    logic       emit;
    emit_kind_t kind;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic dropping;
    logic has_char;
    logic str_end;
    logic is_digit;
    logic held_valid_eff;
    logic held_valid;
    logic at_limit;
    logic pad_more_now;
    logic pad_more_after;
    logic out_free;
  } dp_status_t;

endpackage

/* design/bdp_regs.sv */
`timescale 1ns / 1ps

module bdp_regs
  import bdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic       wr_en;
  reg_index_t idx;

  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_index_t'(paddr[3:2]);
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_SKIP_FIRST:     cfg.skip_first     <= pwdata[0];
        REG_LEADING_NIBBLE: cfg.leading_nibble <= pwdata[3:0];
        REG_PAD_ENABLE:     cfg.pad_enable     <= pwdata[0];
        REG_OCTET_LENGTH:   cfg.octet_length   <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (idx)
      REG_SKIP_FIRST:     prdata = 32'(cfg.skip_first);
      REG_LEADING_NIBBLE: prdata = 32'(cfg.leading_nibble);
      REG_PAD_ENABLE:     prdata = 32'(cfg.pad_enable);
      REG_OCTET_LENGTH:   prdata = 32'(cfg.octet_length);
      default:            prdata = '0;
    endcase
  end

endmodule

/* design/bdp_dpath.sv */
`timescale 1ns / 1ps

module bdp_dpath
  import bdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  dp_cmd_t     cmd,
  output dp_status_t  st,
  input  logic [7:0]  character,
  input  logic        has_character,
  input  logic        string_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  octet,
  output logic        run_last,
  output logic [1:0]  status
);

  // item latched at the input transfer
  logic [7:0]        item_char;
  logic              item_has;
  logic              item_end;

  // per-string state
  logic [3:0]        held_nibble;
  logic              held_valid;
  logic              at_string_start;
  logic [SENT_W-1:0] octets_sent;
  logic              dropping;

  logic [3:0]        held_eff;
  logic              hv_eff;
  logic [3:0]        digit;
  logic [SENT_W-1:0] limit;
  logic [SENT_W-1:0] sent_inc;
  logic              pad_on;
  logic              len_open;

  // leading nibble takes effect at the first item of a string
  assign hv_eff   = (at_string_start && cfg.skip_first) ? 1'b1 : held_valid;
  assign held_eff = (at_string_start && cfg.skip_first) ? cfg.leading_nibble : held_nibble;
  assign digit    = 4'(item_char - CHAR_ZERO);

  // octet limit; a zero length or one above the maximum gives the maximum
  assign len_open = (int'(cfg.octet_length) == 0) || (int'(cfg.octet_length) > MAX_OCTETS);
  assign limit    = len_open ? SENT_W'(MAX_OCTETS) : SENT_W'(cfg.octet_length);
  assign sent_inc = octets_sent + SENT_W'(1);
  assign pad_on   = cfg.pad_enable && (cfg.octet_length != '0);

  // status to the controller
  always_comb begin
    st.dropping       = dropping;
    st.has_char       = item_has;
    st.str_end        = item_end;
    st.is_digit       = (item_char >= CHAR_ZERO) && (item_char <= CHAR_NINE);
    st.held_valid_eff = hv_eff;
    st.held_valid     = held_valid;
    st.at_limit       = octets_sent >= limit;
    st.pad_more_now   = pad_on && (octets_sent < limit);
    st.pad_more_after = pad_on && (sent_inc < limit);
    st.out_free       = !out_valid || !out_stall;
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_char <= character;
      item_has  <= has_character;
      item_end  <= string_end;
    end
  end

  // string state
  always_ff @(posedge clk) begin
    if (rst || cmd.new_string) begin
      held_nibble     <= '0;
      held_valid      <= 1'b0;
      at_string_start <= 1'b1;
      octets_sent     <= '0;
      dropping        <= 1'b0;
    end else begin
      // held nibble: a new digit, a consumed pair, or the leading nibble
      if (cmd.hold_digit) begin
        held_nibble <= digit;
        held_valid  <= 1'b1;
      end else if (cmd.clear_held) begin
        held_valid <= 1'b0;
      end else if (cmd.settle) begin
        held_nibble <= held_eff;
        held_valid  <= hv_eff;
      end
      if (cmd.settle) begin
        at_string_start <= 1'b0;
      end
      if (cmd.count) begin
        octets_sent <= sent_inc;
      end
      if (cmd.drop) begin
        dropping <= 1'b1;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      run_last <= cmd.last;
      case (cmd.kind)
        EK_BAD_CHAR: begin
          octet  <= '0;
          status <= ST_BAD_CHAR;
        end
        EK_TOO_LONG: begin
          octet  <= '0;
          status <= ST_TOO_LONG;
        end
        EK_PAIR: begin
          octet  <= {digit, held_eff};
          status <= ST_OK;
        end
        EK_TAIL: begin
          octet  <= {FILL_NIBBLE, held_nibble};
          status <= ST_OK;
        end
        default: begin
          octet  <= PAD_OCTET;
          status <= ST_OK;
        end
      endcase
    end
  end

endmodule

/* design/bdp_ctrl.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bdp_ctrl
  import bdp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.kind   = EK_PAD;
    in_stall   = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (st.out_free) begin
          state_next = S_IDLE;
          if (st.dropping) begin
            cmd.new_string = st.str_end;
          end else if (!st.has_char && !st.str_end) begin
            // nothing to do for an empty item mid-string
          end else if (st.has_char && !st.is_digit) begin
            cmd.emit       = 1'b1;
            cmd.kind       = EK_BAD_CHAR;
            cmd.last       = 1'b1;
            cmd.new_string = st.str_end;
            cmd.drop       = !st.str_end;
          end else if (st.has_char && st.held_valid_eff) begin
            cmd.emit = 1'b1;
            if (st.at_limit) begin
              cmd.kind       = EK_TOO_LONG;
              cmd.last       = 1'b1;
              cmd.new_string = st.str_end;
              cmd.drop       = !st.str_end;
            end else begin
              cmd.kind       = EK_PAIR;
              cmd.settle     = 1'b1;
              cmd.clear_held = 1'b1;
              cmd.count      = 1'b1;
              cmd.last       = st.str_end && !st.pad_more_after;
              cmd.new_string = cmd.last;
              if (st.str_end && !cmd.last) begin
                state_next = S_PAD;
              end
            end
          end else if (st.has_char) begin
            cmd.settle     = 1'b1;
            cmd.hold_digit = 1'b1;
            if (st.str_end) begin
              state_next = S_TAIL;
            end
          end else begin
            // end without character
            cmd.settle = 1'b1;
            state_next = S_TAIL;
          end
        end
      end
      S_TAIL: begin
        if (st.out_free) begin
          state_next = S_IDLE;
          if (st.held_valid) begin
            cmd.emit = 1'b1;
            if (st.at_limit) begin
              cmd.kind       = EK_TOO_LONG;
              cmd.last       = 1'b1;
              cmd.new_string = 1'b1;
            end else begin
              cmd.kind       = EK_TAIL;
              cmd.clear_held = 1'b1;
              cmd.count      = 1'b1;
              cmd.last       = !st.pad_more_after;
              cmd.new_string = cmd.last;
              if (!cmd.last) begin
                state_next = S_PAD;
              end
            end
          end else if (st.pad_more_now) begin
            state_next = S_PAD;
          end else begin
            cmd.new_string = 1'b1;
          end
        end
      end
      S_PAD: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = EK_PAD;
          cmd.count = 1'b1;
          cmd.last  = !st.pad_more_after;
          if (cmd.last) begin
            cmd.new_string = 1'b1;
            state_next     = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // a result is only loaded into a free output register
  `ASSERT_IMPLY(a_emit_needs_slot, clk, rst, cmd.emit, st.out_free)
  // restarting a string and entering drop mode exclude each other
  `ASSERT_NEVER(a_drop_and_restart, clk, rst, cmd.drop && cmd.new_string)
  // padding only runs while the string is short of its length
  `ASSERT_IMPLY(a_pad_has_room, clk, rst, state == S_PAD, st.pad_more_now)
  // the octet count never passes the limit
  `ASSERT_IMPLY(a_count_in_range, clk, rst, cmd.count, !st.at_limit)

endmodule

/* design/bcd_digit_packer.sv */
`timescale 1ns / 1ps

// packs an ascii decimal digit string into tbcd octets, earlier digit in
// the low nibble, odd tail filled with 0xF, optional 0xFF padding
// input channel: in_valid / in_stall with character, has_character and
// string_end; a transfer happens when in_valid is high and in_stall low
// output channel: out_valid / out_stall with octet, run_last and status;
// run_last marks the final result of a string, status flags bad
// characters and length overruns (rest of the string is then dropped)
// config: apb-style port, registers at 0x0 skip_first, 0x4
// leading_nibble, 0x8 pad_enable, 0xc octet_length; write only while idle
// the sequencer captures an item, then evaluates it, and takes no new
// item until it is back in idle; an end item that leaves an odd digit
// held or carries no character then takes a tail step, and each padding
// octet takes a step of its own; a pair octet passes the item register
// and then the output register, a tail octet also the tail state
// a stalled receiver holds the output register and the sequencer waits
// reset clears config and string state; no clearing pass is needed
module bcd_digit_packer
  import bdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  character,
  input  logic        has_character,
  input  logic        string_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  octet,
  output logic        run_last,
  output logic [1:0]  status
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t st;

  // configuration registers
  bdp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer
  bdp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // string state and output register
  bdp_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .st            (st),
    .character     (character),
    .has_character (has_character),
    .string_end    (string_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .octet         (octet),
    .run_last      (run_last),
    .status        (status)
  );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import bdp_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int SETTLE       = 10;
  localparam int RANDOM_ITEMS = 180;

  // one packed octet as it leaves the block
  typedef struct {
    logic [7:0] octet;
    logic       run_last;
    status_t    status;
  } octet_rec_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  character = '0;
  logic        has_character = 1'b0;
  logic        string_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  octet;
  logic        run_last;
  logic [1:0]  status;

  bcd_digit_packer dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .character(character),
    .has_character(has_character), .string_end(string_end),
    .out_valid(out_valid), .out_stall(out_stall), .octet(octet),
    .run_last(run_last), .status(status)
  );

  // expected octets in order and checker bookkeeping
  octet_rec_t octets_due[$];
  octet_rec_t due_head;
  int         errors = 0;
  int         items_sent = 0;
  int         cycle_count = 0;

  // idle control for the sender and the receiver
  int gap_pct = 30;
  int stall_pct = 25;
  int hold_len = 0;
  int stall_left = 0;

  // shadow of the config registers and of the packer's string state
  cfg_t       shadow_cfg = '0;
  logic [3:0] held_digit = '0;
  bit         held_full = 1'b0;
  bit         awaiting_first = 1'b1;
  int         string_octets = 0;
  bit         discarding = 1'b0;
  int         batch_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold when a test asks for one
  always @(posedge clk) begin
    if (hold_len > 0) begin
      out_stall <= 1'b1;
      hold_len <= hold_len - 1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare every output transfer with the oldest expected octet
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (octets_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual octet=%02h run_last=%0d status=%0d",
                 $time, octet, run_last, status);
        errors++;
      end else begin
        due_head = octets_due.pop_front();
        if (octet !== due_head.octet || run_last !== due_head.run_last ||
            status !== due_head.status) begin
          $display("%0t: mismatch expected octet=%02h run_last=%0d status=%0d, %s%02h %0d %0d",
                   $time, due_head.octet, due_head.run_last, due_head.status,
                   "actual octet/run_last/status=", octet, run_last, status);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // packing predictor
  // ---------------------------------------------------------------

  function automatic int octet_cap();
    if (shadow_cfg.octet_length == 0 || shadow_cfg.octet_length > MAX_OCTETS)
      return MAX_OCTETS;
    return int'(shadow_cfg.octet_length);
  endfunction

  function automatic void add_octet(input logic [7:0] o, input logic fin, input status_t st);
    octet_rec_t rec;
    rec.octet = o;
    rec.run_last = fin;
    rec.status = st;
    octets_due.push_back(rec);
    batch_count++;
  endfunction

  function automatic void restart_string();
    held_digit = '0;
    held_full = 1'b0;
    awaiting_first = 1'b1;
    string_octets = 0;
    discarding = 1'b0;
  endfunction

  // error ends the string here, or drops the rest of it
  function automatic void abort_string(input logic fin);
    if (fin)
      restart_string();
    else
      discarding = 1'b1;
  endfunction

  // zero when the octet would overrun the length limit
  function automatic bit emit_octet(input logic [7:0] o);
    if (string_octets >= octet_cap()) begin
      add_octet(8'h00, 1'b1, ST_TOO_LONG);
      return 1'b0;
    end
    add_octet(o, 1'b0, ST_OK);
    string_octets++;
    return 1'b1;
  endfunction

  task automatic predict_packing(input logic [7:0] ch, input logic has, input logic fin);
    logic [7:0] dig;
    bit         ok;
    batch_count = 0;
    if (discarding) begin
      if (fin)
        restart_string();
      return;
    end
    if (!has && !fin)
      return;
    if (awaiting_first) begin
      if (shadow_cfg.skip_first) begin
        held_digit = shadow_cfg.leading_nibble;
        held_full = 1'b1;
      end
      awaiting_first = 1'b0;
    end
    if (has) begin
      if (ch < CHAR_ZERO || ch > CHAR_NINE) begin
        add_octet(8'h00, 1'b1, ST_BAD_CHAR);
        abort_string(fin);
        return;
      end
      dig = ch - CHAR_ZERO;
      if (held_full) begin
        held_full = 1'b0;
        if (!emit_octet({dig[3:0], held_digit})) begin
          abort_string(fin);
          return;
        end
      end else begin
        held_digit = dig[3:0];
        held_full = 1'b1;
      end
    end
    if (fin) begin
      ok = 1'b1;
      if (held_full)
        ok = emit_octet({FILL_NIBBLE, held_digit});
      if (ok && shadow_cfg.pad_enable && shadow_cfg.octet_length != 0)
        while (string_octets < octet_cap())
          void'(emit_octet(PAD_OCTET));
      if (ok && batch_count > 0)
        octets_due[octets_due.size() - 1].run_last = 1'b1;
      restart_string();
    end
  endtask

  // ---------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------

  function automatic int pick_gap();
    if ($urandom_range(0, 99) >= gap_pct)
      return 0;
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // one input transfer; prediction happens once the sequencer takes input again
  task automatic send_item(input logic [7:0] ch, input logic has, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    character <= ch;
    has_character <= has;
    string_end <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_packing(ch, has, fin);
    if (has || fin)
      items_sent++;
  endtask

  // setup then access; the caller ends the bus activity after the last write
  task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_SKIP_FIRST:     shadow_cfg.skip_first = val[0];
      REG_LEADING_NIBBLE: shadow_cfg.leading_nibble = val[3:0];
      REG_PAD_ENABLE:     shadow_cfg.pad_enable = val[0];
      REG_OCTET_LENGTH:   shadow_cfg.octet_length = val[LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic skip, input logic [3:0] lead, input logic pad,
                               input logic [5:0] len);
    write_reg(REG_SKIP_FIRST, 32'(skip));
    write_reg(REG_LEADING_NIBBLE, 32'(lead));
    write_reg(REG_PAD_ENABLE, 32'(pad));
    write_reg(REG_OCTET_LENGTH, 32'(len));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // stop offering, let every expected octet arrive, then let dropped items settle
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (octets_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [7:0] bad_char();
    logic [7:0] ch;
    case ($urandom_range(0, 3))
      0:       ch = CHAR_ZERO - 8'd1;
      1:       ch = CHAR_NINE + 8'd1;
      default: begin
        do ch = 8'($urandom_range(0, 255)); while (ch >= CHAR_ZERO && ch <= CHAR_NINE);
      end
    endcase
    return ch;
  endfunction

  // digit counts mostly short, some near or past the octet limit
  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7)
      return $urandom_range(0, 7);
    if (r < 9)
      return $urandom_range(0, 2 * octet_cap());
    return $urandom_range(2 * octet_cap() - 1, 2 * octet_cap() + 3);
  endfunction

  // a digit string, optionally with one bad character and a separate end item
  task automatic send_string(input int n_digits, input int bad_pos, input bit end_alone);
    int         i;
    logic [7:0] ch;
    for (i = 0; i < n_digits; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      ch = (i == bad_pos) ? bad_char() : CHAR_ZERO + 8'($urandom_range(0, 9));
      send_item(ch, 1'b1, !end_alone && i == n_digits - 1);
    end
    if (end_alone || n_digits == 0)
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // ---------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------

  task automatic test_plain_strings();
    apply_setting(1'b0, 4'h0, 1'b0, 6'd0);
    send_item("1", 1'b1, 1'b0);
    send_item("9", 1'b1, 1'b1);
    send_item("0", 1'b1, 1'b1);
    // no character and no end: ignored
    send_item(8'hA5, 1'b0, 1'b0);
    // empty string gives nothing
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h2F, 1'b1, 1'b1);
    // bad character mid-string, rest dropped up to the end item
    send_item("5", 1'b1, 1'b0);
    send_item(8'h3A, 1'b1, 1'b0);
    send_item("7", 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    // odd tail closed by an end item without character
    send_item("4", 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    wait_drain();
  endtask

  task automatic test_padding_and_leading();
    apply_setting(1'b1, 4'hF, 1'b1, 6'd32);
    send_item(8'h00, 1'b0, 1'b1);
    send_item("8", 1'b1, 1'b0);
    send_item("2", 1'b1, 1'b1);
    wait_drain();
    // padding with no length set adds nothing
    apply_setting(1'b1, 4'h0, 1'b1, 6'd0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item("1", 1'b1, 1'b1);
    wait_drain();
  endtask

  task automatic test_length_limit();
    apply_setting(1'b0, 4'h0, 1'b0, 6'd1);
    // overrun on a digit pair, then the rest is dropped
    send_item("1", 1'b1, 1'b0);
    send_item("2", 1'b1, 1'b0);
    send_item("3", 1'b1, 1'b0);
    send_item("4", 1'b1, 1'b0);
    send_item("5", 1'b1, 1'b1);
    // overrun on the filled tail
    send_item("1", 1'b1, 1'b0);
    send_item("2", 1'b1, 1'b0);
    send_item("3", 1'b1, 1'b1);
    wait_drain();
    // length above the maximum saturates
    apply_setting(1'b0, 4'h9, 1'b1, 6'd63);
    send_item("6", 1'b1, 1'b1);
    wait_drain();
  endtask

  task automatic test_backpressure();
    apply_setting(1'b1, 4'h3, 1'b1, 6'd12);
    // receiver holds off while strings keep coming
    hold_len <= 150;
    repeat (4) send_string(5, -1, 1'b0);
    wait_drain();
    // sender pauses mid-string until everything is out
    send_item("1", 1'b1, 1'b0);
    send_item("2", 1'b1, 1'b0);
    send_item("3", 1'b1, 1'b0);
    wait_drain();
    send_item("4", 1'b1, 1'b1);
    wait_drain();
  endtask

  task automatic test_back_to_back();
    gap_pct = 0;
    stall_pct = 0;
    apply_setting(1'b0, 4'h5, 1'b1, 6'd6);
    repeat (6) send_string($urandom_range(0, 12), -1, 1'($urandom_range(0, 1)));
    wait_drain();
    gap_pct = 30;
    stall_pct = 25;
  endtask

  task automatic test_random_strings();
    int goal;
    int phase;
    int phase_goal;
    int r;
    int n;
    goal = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < goal) begin
      case (phase)
        0: apply_setting(1'b0, 4'h0, 1'b0, 6'd0);
        1: apply_setting(1'b1, 4'hF, 1'b1, 6'd32);
        2: apply_setting(1'b1, 4'h0, 1'b1, 6'd1);
        3: apply_setting(1'b0, 4'h7, 1'b1, 6'd63);
        4: apply_setting(1'b0, 4'hA, 1'b0, 6'd1);
        default: apply_setting(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                               1'($urandom_range(0, 1)), 6'($urandom_range(0, 32)));
      endcase
      phase_goal = items_sent + 35;
      while (items_sent < phase_goal && items_sent < goal) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          send_string(pick_length(), -1, 1'($urandom_range(0, 1)));
        end else if (r < 92) begin
          n = $urandom_range(1, 8);
          send_string(n, $urandom_range(0, n - 1), 1'($urandom_range(0, 1)));
        end else begin
          send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        end
      end
      // a dropped string must be closed before the next setting
      if (discarding)
        send_item(8'h00, 1'b0, 1'b1);
      wait_drain();
      phase++;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_plain_strings();
    test_padding_and_leading();
    test_length_limit();
    test_backpressure();
    test_back_to_back();
    test_random_strings();
    wait_drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/bdp_pkg.sv
design/bdp_regs.sv
design/bdp_dpath.sv
design/bdp_ctrl.sv
design/bcd_digit_packer.sv
dv/testbench.sv
